>>> hw/rtl/wma_pkg.sv
// Shared constants and types for the windowed moving average block.
package wma_pkg;

    localparam int WINDOW   = 16;
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 8;
    localparam int AVG_W    = 24;
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int DVD_W    = SUM_W + FRAC_W;
    localparam int ITER_W   = $clog2(DVD_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } wma_state_t;

endpackage

>>> hw/rtl/windowed_moving_average.sv
// Windowed moving average: mean of the last WINDOW samples over a ring memory.
// Each sample item reads the oldest entry from the ring memory, updates the
// exact running sum, writes the new sample back and then divides sum * 256 by
// the number of held samples in a bit-serial divider, one quotient bit per
// cycle. A sample item passes through the read, divide and output states:
// its result is loaded into the output register once the divider is done,
// and the next item can enter after that. A clear item goes straight to the
// output state, gives a zero average and restarts warm-up. One item is in
// flight at a time; the result register lets the next item enter while a
// result waits, and a finished result stalls while the one before it is
// still waiting.
module windowed_moving_average
    import wma_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_clear,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [AVG_W-1:0]    m_average,
    output logic                       m_window_full
);

    wma_state_t state_reg;
    wma_state_t state_next;

    logic                       s_accept;
    logic                       rd_en;
    logic                       wr_en;
    logic                       div_start;
    logic                       out_load;
    logic                       div_done;
    logic signed [DVD_W-1:0]    div_quot;
    logic signed [SAMPLE_W-1:0] rd_data;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PTR_W-1:0]           pos_reg;
    logic [PTR_W-1:0]           pos_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       filled_reg;
    logic                       filled_next;
    logic [CNT_W-1:0]           pos_inc;
    logic                       wrap;
    logic [CNT_W-1:0]           count;
    logic signed [SUM_W-1:0]    old_ext;
    logic signed [SUM_W-1:0]    new_ext;
    logic signed [DVD_W-1:0]    dividend;

    logic signed [AVG_W-1:0]    res_avg_reg;
    logic                       res_full_reg;
    logic                       m_valid_reg;
    logic signed [AVG_W-1:0]    m_average_reg;
    logic                       m_window_full_reg;

    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_clear ? ST_OUT : ST_READ;
                end
            end
            ST_READ: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        wr_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_READ: begin
                wr_en     = 1'b1;
                div_start = 1'b1;
            end
            ST_DIV: ;
            ST_OUT: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
        rd_en = s_accept && !s_clear;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        old_ext     = filled_reg ? {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data} : '0;
        new_ext     = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        sum_next    = sum_reg - old_ext + new_ext;
        pos_inc     = CNT_W'(pos_reg) + CNT_W'(1);
        wrap        = (pos_inc == CNT_W'(WINDOW));
        pos_next    = wrap ? '0 : pos_inc[PTR_W-1:0];
        filled_next = filled_reg || wrap;
        count       = filled_next ? CNT_W'(WINDOW) : pos_inc;
        dividend    = {sum_next, {FRAC_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            filled_reg <= 1'b0;
        end else if (s_accept && s_clear) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            filled_reg <= 1'b0;
        end else if (wr_en) begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_sample;
        end
        if (s_accept && s_clear) begin
            res_avg_reg  <= '0;
            res_full_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                res_full_reg <= filled_next;
            end
            if (div_done) begin
                res_avg_reg <= div_quot[AVG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_average_reg     <= res_avg_reg;
            m_window_full_reg <= res_full_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_average     = m_average_reg;
    assign m_window_full = m_window_full_reg;

    wma_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    wma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

>>> hw/rtl/wma_ram.sv
// Sample ring memory: one write port, one read port with registered read data.
module wma_ram
    import wma_pkg::*;
(
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [PTR_W-1:0]           wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [PTR_W-1:0]           rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [WINDOW];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/wma_div.sv
// Serial restoring divider: signed dividend by unsigned count, truncated toward zero.
module wma_div
    import wma_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);

    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic              done_reg;
    logic              done_next;
    logic              neg_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W:0]    rem_sh;
    logic              qbit;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        qbit      = (rem_sh >= {1'b0, dsr_reg});
        rem_next  = qbit ? CNT_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[CNT_W-1:0];
        dvd_next  = {dvd_reg[DVD_W-2:0], qbit};
        iter_next = iter_reg - ITER_W'(1);
        done_next = (iter_reg == ITER_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            iter_reg <= ITER_W'(DVD_W);
            done_reg <= 1'b0;
        end else if (iter_reg != '0) begin
            iter_reg <= iter_next;
            done_reg <= done_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DVD_W-1];
            dvd_reg <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (iter_reg != '0) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

endmodule
